// File: src/mvs_pkg.sv
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared widths, status codes and sequencer states for the mean, variance
// and standard deviation engine.
// ----------------------------------------------------------------------------
package mvs_pkg;

    // payload widths
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 27;
    localparam int TOTAL_W     = 26;
    localparam int VAR_W       = 32;
    localparam int ROOT_W      = 16;
    localparam int COUNT_OUT_W = 11;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 1;

    // default store depth
    localparam int DEF_MAX_SAMPLES = 1024;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_DOF  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MEAN = 6'b000010,
        ST_PASS = 6'b000100,
        ST_VAR  = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

// File: src/mvs_if.sv
// ----------------------------------------------------------------------------
// mvs_in_if / mvs_out_if
// Valid/ready channels carrying samples in and statistics results out.
// ----------------------------------------------------------------------------
interface mvs_in_if;
    import mvs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

interface mvs_out_if;
    import mvs_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [TOTAL_W-1:0]     total;
    logic signed [SAMPLE_W-1:0]    average;
    logic        [VAR_W-1:0]       spread_squared;
    logic        [ROOT_W-1:0]      spread;
    logic        [COUNT_OUT_W-1:0] sample_count;
    logic        [STATUS_W-1:0]    status;

    modport source (output valid, total, average, spread_squared, spread, sample_count,
                    status, input ready);
    modport sink   (input valid, total, average, spread_squared, spread, sample_count,
                    status, output ready);
endinterface

// File: src/mvs_ram.sv
// ----------------------------------------------------------------------------
// mvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mvs_div.sv
// ----------------------------------------------------------------------------
// mvs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvs_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_BITS = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]    quot_reg, quot_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_W:0]      rem_sh;
    logic                ge;

    // one restoring step
    assign rem_sh = {rem_reg, quot_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], ge};
            rem_next  = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: src/mvs_sqrt.sv
// ----------------------------------------------------------------------------
// mvs_sqrt
// Floor integer square root of a 32-bit value, one bit pair per cycle.
// ----------------------------------------------------------------------------
module mvs_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mvs_pkg::VAR_W-1:0]     radicand,
    output logic                          done,
    output logic [mvs_pkg::ROOT_W-1:0]    root
);
    import mvs_pkg::*;

    logic [VAR_W-1:0] rem_reg, rem_next;
    logic [VAR_W-1:0] res_reg, res_next;
    logic [VAR_W-1:0] bit_reg, bit_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VAR_W:0]   trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    // one digit step
    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = VAR_W'(1) << (VAR_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = VAR_W'({1'b0, rem_reg} - trial);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// File: src/mean_variance_stddev_engine.sv
// ----------------------------------------------------------------------------
// mean_variance_stddev_engine
// Two-pass mean, variance and standard deviation over a set of Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch takes one signed Q8.8 sample per transaction; the transaction
//   with last set closes the set. Samples beyond MAX_SAMPLES are dropped and
//   flagged in status. result_ch delivers one transaction per set: total,
//   average, variance (Q16.16), standard deviation (Q8.8), count and status.
//   cfg_we/cfg_wdata write divisor_offset (0 population, 1 sample variance).
// Timing:
//   non-last samples are taken one per cycle while idle. After the last
//   sample one shared restoring divider (one bit per cycle) forms the mean,
//   a pass over the sample RAM (one read per cycle) sums squared deviations,
//   the same divider forms the variance and a 16-step unit takes the root;
//   with no degrees of freedom those two steps are skipped and both are zero.
// Reset and stall:
//   reset empties the set and sets divisor_offset to 0; RAM contents are not
//   cleared. A result held by a stalled receiver stays in the output register;
//   new samples are still taken, and the next set finishes and waits in its
//   final state until the output register is free.
// ----------------------------------------------------------------------------
module mean_variance_stddev_engine #(
    parameter int MAX_SAMPLES = mvs_pkg::DEF_MAX_SAMPLES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mvs_pkg::CFG_W-1:0] cfg_wdata,
    mvs_in_if.sink                    sample_ch,
    mvs_out_if.source                 result_ch
);
    import mvs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int SQ_W   = 2 * SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int DIV_W  = SQ_W;

    state_t                     state_reg, state_next;
    logic                       offset_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       drop_reg, drop_next;
    logic [CNT_W-1:0]           n_reg;
    logic [SUM_W-1:0]           tot_reg;
    logic                       drop_set_reg;
    logic signed [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [SQ_W-1:0]            acc_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic                       rd_vld_reg;
    logic [VAR_W-1:0]           term_reg;
    logic                       term_vld_reg;
    logic [VAR_W-1:0]           var_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic                       div_start_reg, div_start_next;
    logic                       root_start_reg, root_start_next;
    logic                       out_valid_reg;
    logic                       out_load;

    logic                       in_acc;
    logic                       has_room;
    logic                       issue;
    logic                       pass_end;
    logic [CNT_W-1:0]           denom;
    logic                       no_dof;
    logic [SUM_W-1:0]           abs_sum;
    logic [DIV_W-1:0]           div_numer;
    logic [CNT_W-1:0]           div_denom;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quot;
    logic                       root_done;
    logic [ROOT_W-1:0]          root_val;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W:0]   dev;
    logic [SAMPLE_W-1:0]        abs_dev;
    logic [STATUS_W-1:0]        status_val;

    logic signed [TOTAL_W-1:0]     total_out_reg;
    logic signed [SAMPLE_W-1:0]    average_out_reg;
    logic        [VAR_W-1:0]       var_out_reg;
    logic        [ROOT_W-1:0]      root_out_reg;
    logic        [COUNT_OUT_W-1:0] count_out_reg;
    logic        [STATUS_W-1:0]    status_out_reg;

    // input handshake and set loading
    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign in_acc          = sample_ch.valid && sample_ch.ready;
    assign has_room        = count_reg < CNT_W'(MAX_SAMPLES);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        drop_next  = drop_reg;
        if (has_room)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + {{(SUM_W - SAMPLE_W){sample_ch.sample[SAMPLE_W-1]}},
                                    sample_ch.sample};
        end
        else
        begin
            drop_next = 1'b1;
        end
    end

    // sample store
    mvs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (in_acc && has_room),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (sample_ch.sample),
        .re    (issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // shared divider: mean first, then variance
    assign abs_sum   = tot_reg[SUM_W-1] ? (~tot_reg + 1'b1) : tot_reg;
    assign denom     = n_reg - CNT_W'(offset_reg);
    assign no_dof    = (denom == '0);
    assign div_numer = (state_reg == ST_MEAN) ? DIV_W'(abs_sum) : DIV_W'(acc_reg);
    assign div_denom = (state_reg == ST_MEAN) ? n_reg : denom;

    mvs_div #(
        .NUM_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    // square root unit
    mvs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start_reg),
        .radicand (var_reg),
        .done     (root_done),
        .root     (root_val)
    );

    // signed, saturated mean from the magnitude quotient
    always_comb
    begin
        if (tot_reg[SUM_W-1])
        begin
            if (div_quot > DIV_W'(32768))
            begin
                mean_next = 16'sh8000;
            end
            else
            begin
                mean_next = -$signed(div_quot[SAMPLE_W-1:0]);
            end
        end
        else
        begin
            if (div_quot > DIV_W'(32767))
            begin
                mean_next = 16'sh7fff;
            end
            else
            begin
                mean_next = $signed(div_quot[SAMPLE_W-1:0]);
            end
        end
    end

    // deviation pass: read, square, accumulate
    assign issue    = (state_reg == ST_PASS) && (idx_reg < n_reg);
    assign pass_end = (state_reg == ST_PASS) && (idx_reg == n_reg) &&
                      !rd_vld_reg && !term_vld_reg;
    assign dev      = $signed({rd_data[SAMPLE_W-1], rd_data}) -
                      $signed({mean_reg[SAMPLE_W-1], mean_reg});
    assign abs_dev  = dev[SAMPLE_W] ? SAMPLE_W'(-dev) : dev[SAMPLE_W-1:0];

    // result status
    always_comb
    begin
        priority if (no_dof)
        begin
            status_val = STATUS_NO_DOF;
        end
        else if (drop_set_reg)
        begin
            status_val = STATUS_DROPPED;
        end
        else
        begin
            status_val = STATUS_OK;
        end
    end

    // sequencer
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        div_start_next  = 1'b0;
        root_start_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && sample_ch.last)
                begin
                    state_next     = ST_MEAN;
                    div_start_next = 1'b1;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (pass_end)
                begin
                    if (no_dof)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next     = ST_VAR;
                        div_start_next = 1'b1;
                    end
                end
            end
            ST_VAR:
            begin
                if (div_done)
                begin
                    state_next      = ST_ROOT;
                    root_start_next = 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            offset_reg     <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            drop_reg       <= 1'b0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            term_vld_reg   <= 1'b0;
            div_start_reg  <= 1'b0;
            root_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            div_start_reg  <= div_start_next;
            root_start_reg <= root_start_next;
            rd_vld_reg     <= issue;
            term_vld_reg   <= rd_vld_reg;

            if (cfg_we)
            begin
                offset_reg <= cfg_wdata[0];
            end

            // running set state, cleared when the set closes
            if (in_acc)
            begin
                if (sample_ch.last)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    drop_reg  <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                    drop_reg  <= drop_next;
                end
            end

            // pass read index
            if ((state_reg == ST_MEAN) && div_done)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc && sample_ch.last)
        begin
            n_reg        <= count_next;
            tot_reg      <= sum_next;
            drop_set_reg <= drop_next;
        end

        if ((state_reg == ST_MEAN) && div_done)
        begin
            mean_reg <= mean_next;
            acc_reg  <= '0;
        end
        else if (term_vld_reg)
        begin
            acc_reg <= acc_reg + SQ_W'(term_reg);
        end

        if (rd_vld_reg)
        begin
            term_reg <= VAR_W'(abs_dev) * VAR_W'(abs_dev);
        end

        if (pass_end && no_dof)
        begin
            var_reg  <= '0;
            root_reg <= '0;
        end
        else if ((state_reg == ST_VAR) && div_done)
        begin
            var_reg <= (div_quot > DIV_W'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : div_quot[VAR_W-1:0];
        end
        else if ((state_reg == ST_ROOT) && root_done)
        begin
            root_reg <= root_val;
        end

        if (out_load)
        begin
            total_out_reg   <= tot_reg[TOTAL_W-1:0];
            average_out_reg <= mean_reg;
            var_out_reg     <= var_reg;
            root_out_reg    <= root_reg;
            count_out_reg   <= COUNT_OUT_W'(n_reg);
            status_out_reg  <= status_val;
        end
    end

    // result channel
    assign result_ch.valid          = out_valid_reg;
    assign result_ch.total          = total_out_reg;
    assign result_ch.average        = average_out_reg;
    assign result_ch.spread_squared = var_out_reg;
    assign result_ch.spread         = root_out_reg;
    assign result_ch.sample_count   = count_out_reg;
    assign result_ch.status         = status_out_reg;

endmodule

// File: src/mvs_checker.sv
// ----------------------------------------------------------------------------
// mvs_checker
// Port-level checks for the statistics engine, bound to the top level.
// ----------------------------------------------------------------------------
module mvs_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               in_last,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [mvs_pkg::TOTAL_W-1:0] total,
    input logic signed [mvs_pkg::SAMPLE_W-1:0] average,
    input logic [mvs_pkg::VAR_W-1:0]          spread_squared,
    input logic [mvs_pkg::ROOT_W-1:0]         spread,
    input logic [mvs_pkg::COUNT_OUT_W-1:0]    sample_count,
    input logic [mvs_pkg::STATUS_W-1:0]       status
);
    import mvs_pkg::*;

    logic [VAR_W+1:0] root_sq;
    logic [VAR_W+1:0] root_up_sq;

    assign root_sq    = (VAR_W + 2)'(spread) * (VAR_W + 2)'(spread);
    assign root_up_sq = ((VAR_W + 2)'(spread) + 1'b1) * ((VAR_W + 2)'(spread) + 1'b1);

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total) && $stable(average) &&
        $stable(spread_squared) && $stable(spread) && $stable(sample_count) &&
        $stable(status))
        else $error("result changed while stalled");

    // closing a set makes the block busy
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input ready right after last sample");

    // the root is the floor square root of the variance
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (root_sq <= (VAR_W + 2)'(spread_squared)) &&
        (root_up_sq > (VAR_W + 2)'(spread_squared)))
        else $error("spread is not the floor root of spread_squared");

    // no degrees of freedom yields zero spread
    a_no_dof_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_NO_DOF) |-> (spread_squared == '0) && (spread == '0))
        else $error("nonzero spread with no degrees of freedom");

endmodule

bind mean_variance_stddev_engine mvs_checker u_mvs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_ch.valid),
    .in_ready       (sample_ch.ready),
    .in_last        (sample_ch.last),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .total          (result_ch.total),
    .average        (result_ch.average),
    .spread_squared (result_ch.spread_squared),
    .spread         (result_ch.spread),
    .sample_count   (result_ch.sample_count),
    .status         (result_ch.status)
);

// File: tb/sv/mean_variance_stddev_engine_tb.sv
// ----------------------------------------------------------------------------
// mean_variance_stddev_engine_tb
// Self-checking bench for the mean, variance and standard deviation engine.
// Sample sets go in through a queue-fed driver. A predictor computes total,
// mean, variance, root, count and status for each closed set, and the result
// monitor checks every field. Sets are short, random or hand-picked, plus one
// full-store set that overflows, under several idle/stall mixes and both
// divisor settings.
// ----------------------------------------------------------------------------
module mean_variance_stddev_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvs_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_SAMPLES;
    localparam int HOLD_CYCLES = 2500;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_item_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0]  total;
        logic signed [SAMPLE_W-1:0] average;
        logic [VAR_W-1:0]           spread_squared;
        logic [ROOT_W-1:0]          spread;
        logic [COUNT_OUT_W-1:0]     sample_count;
        logic [STATUS_W-1:0]        status;
    } set_stats_t;

    typedef enum int {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_RAILS, SPREAD_TINY} spread_style_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    mvs_in_if  sample_ch();
    mvs_out_if result_ch();

    mean_variance_stddev_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    // stimulus and expectation queues
    sample_item_t pending_samples[$];
    set_stats_t   stats_expected[$];

    // predictor copy of the block state
    logic signed [SAMPLE_W-1:0] set_samples[$];
    logic [SUM_W-1:0]           set_sum = '0;
    bit                         set_dropped = 1'b0;
    bit                         offset_model = 1'b0;

    int  mismatch_count = 0;
    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    bit  hold_request = 1'b0;
    bit  sample_taken = 1'b0;

    // clock
    always #5 clk = ~clk;

    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [VAR_W-1:0] v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] t;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (ROOT_W'(1) << b);
            if (longint'(t) * longint'(t) <= longint'(v))
                r = t;
        end
        return r;
    endfunction

    // fold one accepted sample into the set, close the set on last
    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s, input bit is_last);
        set_stats_t          res;
        longint              n;
        longint              sum_v;
        longint              mean_v;
        longint              d;
        longint unsigned     sq;
        longint unsigned     var_v;
        longint unsigned     denom;
        if (set_samples.size() < STORE_DEPTH)
        begin
            set_samples.insert(set_samples.size(), s);
            set_sum = set_sum + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
        end
        else
            set_dropped = 1'b1;
        if (!is_last)
            return;

        n      = set_samples.size();
        sum_v  = longint'($signed(set_sum));
        mean_v = (n != 0) ? sum_v / n : 0;
        if (mean_v > 32767)
            mean_v = 32767;
        if (mean_v < -32768)
            mean_v = -32768;

        // second pass over the stored samples
        sq = 0;
        foreach (set_samples[i])
        begin
            d  = longint'(set_samples[i]) - mean_v;
            d  = (d < 0) ? -d : d;
            sq += longint'(d) * longint'(d);
        end

        denom = (n >= offset_model) ? longint'(n - offset_model) : 0;
        res.total          = set_sum[TOTAL_W-1:0];
        res.average        = mean_v[SAMPLE_W-1:0];
        res.sample_count   = n[COUNT_OUT_W-1:0];
        if (denom == 0)
        begin
            res.spread_squared = '0;
            res.spread         = '0;
            res.status         = STATUS_NO_DOF;
        end
        else
        begin
            var_v = sq / denom;
            if (var_v > 64'hFFFF_FFFF)
                var_v = 64'hFFFF_FFFF;
            res.spread_squared = var_v[VAR_W-1:0];
            res.spread         = floor_sqrt(var_v[VAR_W-1:0]);
            res.status         = set_dropped ? STATUS_DROPPED : STATUS_OK;
        end
        stats_expected.insert(stats_expected.size(), res);

        set_samples.delete();
        set_sum     = '0;
        set_dropped = 1'b0;
    endtask

    // input side: predict on each accepted transaction, track the register
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            offset_model <= cfg_wdata[0];
        if (rst_n && sample_ch.valid && sample_ch.ready)
            absorb_sample(sample_ch.sample, sample_ch.last);
        sample_taken <= rst_n && sample_ch.valid && sample_ch.ready;
    end

    // sample driver, fed from the pending queue
    always @(negedge clk)
    begin
        sample_item_t nxt;
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
            sample_ch.last   <= 1'b0;
        end
        else if (!sample_ch.valid || sample_taken)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt = pending_samples[0];
                pending_samples.delete(0);
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= nxt.sample;
                sample_ch.last   <= nxt.last;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver ready
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        set_stats_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (stats_expected.size() == 0)
                note_mismatch("result transaction with nothing expected, total",
                              result_ch.total, 0);
            else
            begin
                want = stats_expected[0];
                stats_expected.delete(0);
                if (result_ch.total !== want.total)
                    note_mismatch("total", result_ch.total, want.total);
                if (result_ch.average !== want.average)
                    note_mismatch("average", result_ch.average, want.average);
                if (result_ch.spread_squared !== want.spread_squared)
                    note_mismatch("spread_squared", result_ch.spread_squared,
                                  want.spread_squared);
                if (result_ch.spread !== want.spread)
                    note_mismatch("spread", result_ch.spread, want.spread);
                if (result_ch.sample_count !== want.sample_count)
                    note_mismatch("sample_count", result_ch.sample_count,
                                  want.sample_count);
                if (result_ch.status !== want.status)
                    note_mismatch("status", result_ch.status, want.status);
            end
        end
    end

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input bit is_last);
        sample_item_t item;
        item.sample = s;
        item.last   = is_last;
        pending_samples.insert(pending_samples.size(), item);
    endtask

    // wait for all samples and results, then let the block settle
    task automatic drain_all();
        while (pending_samples.size() != 0 || sample_ch.valid || stats_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_divisor_offset(input bit v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random sets of mostly short length with varied content
    task automatic queue_random_sets(input int budget);
        int                         queued;
        int                         len;
        int                         k;
        spread_style_t              style;
        logic signed [SAMPLE_W-1:0] center;
        logic signed [SAMPLE_W-1:0] s;
        queued = 0;
        while (queued < budget)
        begin
            k = $urandom_range(99);
            if (k < 70)
                len = $urandom_range(8, 1);
            else if (k < 95)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(200, 41);
            style  = spread_style_t'($urandom_range(3));
            center = SAMPLE_W'($urandom);
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    SPREAD_WIDE:    s = SAMPLE_W'($urandom);
                    SPREAD_CLUSTER: s = center + SAMPLE_W'($urandom_range(64)) - 16'sd32;
                    SPREAD_RAILS:   s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    default:        s = SAMPLE_W'($urandom_range(15)) - 16'sd8;
                endcase
                queue_sample(s, i == len - 1);
            end
            queued += len;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets, population variance
        write_divisor_offset(1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b1);
        // mean truncates toward zero on both signs
        queue_sample(-16'sd3, 1'b0);
        queue_sample(-16'sd2, 1'b1);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd2, 1'b1);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sh5555, 1'b0);
        queue_sample(16'shAAAA, 1'b1);
        drain_all();

        // directed sets, sample variance, single sample has no dof
        write_divisor_offset(1'b1);
        queue_sample(16'sd100, 1'b1);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(16'sd1, 1'b0);
        queue_sample(16'sd2, 1'b0);
        queue_sample(16'sd3, 1'b0);
        queue_sample(16'sd4, 1'b1);
        drain_all();

        // store filled at the most negative value, trailing samples dropped
        write_divisor_offset(1'b1);
        for (int i = 0; i < STORE_DEPTH + 3; i++)
            queue_sample(16'sh8000, i == STORE_DEPTH + 2);
        drain_all();

        // receiver holds off while the sender keeps offering sets
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
                queue_sample(SAMPLE_W'($urandom), j == 5);
        @(negedge clk);
        hold_request <= 1'b1;
        @(negedge clk);
        hold_request <= 1'b0;
        drain_all();

        // random sets under each idle mix and both divisor settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase / 2)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 47; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_divisor_offset(phase[0]);
            queue_random_sets(30);
            drain_all();
        end

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/mvs_pkg.sv
src/mvs_if.sv
src/mvs_ram.sv
src/mvs_div.sv
src/mvs_sqrt.sv
src/mean_variance_stddev_engine.sv
src/mvs_checker.sv
tb/sv/mean_variance_stddev_engine_tb.sv
